FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the sprite compositor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on the rising clock edge, off while reset is applied.
`define SWAC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Same check with a message of the caller's choice.
`define SWAC_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

FILE: hw/rtl/swac_pkg.sv
// Types, codes and constants of the sprite compositor.
`timescale 1ns / 1ps

package swac_pkg;

  // Default configuration of the compositor.
  localparam int unsigned DEF_SPRITE_COUNT = 18;
  localparam int unsigned DEF_SPRITE_SIZE  = 64;
  localparam int unsigned DEF_IMAGE_COUNT  = 8;
  localparam int unsigned DEF_LINE_WIDTH   = 320;
  localparam int unsigned DEF_FRAME_LINES  = 240;

  // RGB565 channel fields.
  localparam logic [15:0] RED_FIELD   = 16'hf800;
  localparam logic [15:0] GREEN_FIELD = 16'h07e0;
  localparam logic [15:0] BLUE_FIELD  = 16'h001f;

  // Item kinds.
  typedef enum logic [1:0] {
    OP_SPRITE = 2'd0,
    OP_COVER  = 2'd1,
    OP_PIXEL  = 2'd2
  } op_e;

  // One input item as it travels down the chain.
  typedef struct packed {
    logic [1:0]         operation;
    logic [4:0]         sprite_index;
    logic signed [10:0] sprite_x_pos;
    logic signed [11:0] sprite_y_pos;
    logic [2:0]         image_number;
    logic [5:0]         image_row;
    logic [5:0]         image_col;
    logic [5:0]         alpha_value;
    logic [8:0]         pixel_x;
    logic [7:0]         pixel_y;
    logic [15:0]        background_colour;
  } item_t;

  // An item together with its valid flag.
  typedef struct packed {
    logic  valid;
    item_t item;
  } beat_t;

endpackage

FILE: hw/rtl/swac_in_if.sv
// Input channel of the sprite compositor: commands and background pixels.
`timescale 1ns / 1ps

interface swac_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [4:0]         sprite_index;
  logic signed [10:0] sprite_x_pos;
  logic signed [11:0] sprite_y_pos;
  logic [2:0]         image_number;
  logic [5:0]         image_row;
  logic [5:0]         image_col;
  logic [5:0]         alpha_value;
  logic [8:0]         pixel_x;
  logic [7:0]         pixel_y;
  logic [15:0]        background_colour;

  modport source (
    output valid, operation, sprite_index, sprite_x_pos, sprite_y_pos, image_number,
           image_row, image_col, alpha_value, pixel_x, pixel_y, background_colour,
    input  ready
  );

  modport sink (
    input  valid, operation, sprite_index, sprite_x_pos, sprite_y_pos, image_number,
           image_row, image_col, alpha_value, pixel_x, pixel_y, background_colour,
    output ready
  );
endinterface

FILE: hw/rtl/swac_out_if.sv
// Output channel of the sprite compositor: composited pixels.
`timescale 1ns / 1ps

interface swac_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] blended_colour;

  modport source (
    output valid, blended_colour,
    input  ready
  );

  modport sink (
    input  valid, blended_colour,
    output ready
  );
endinterface

FILE: hw/rtl/swac_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module swac_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; the data holds while the read is not enabled.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/swac_cell.sv
// One compositor cell: holds one sprite entry and its copy of the coverage store.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swac_cell #(
  parameter int unsigned CELL_INDEX  = 0,
  parameter int unsigned SPRITE_SIZE = swac_pkg::DEF_SPRITE_SIZE,
  parameter int unsigned IMAGE_COUNT = swac_pkg::DEF_IMAGE_COUNT,
  parameter int unsigned LINE_WIDTH  = swac_pkg::DEF_LINE_WIDTH,
  parameter int unsigned FRAME_LINES = swac_pkg::DEF_FRAME_LINES
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  swac_pkg::beat_t beat_i,
  output logic            ready_o,
  output swac_pkg::beat_t beat_o,
  input  logic            ready_i
);

  localparam int unsigned PLANE  = SPRITE_SIZE * SPRITE_SIZE;
  localparam int unsigned DEPTH  = IMAGE_COUNT * PLANE;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [11:0] TOP_RESET = 12'sd2047;

  // Pulls each channel toward white by the coverage weight.
  function automatic logic [15:0] toward_white(input logic [15:0] colour,
                                               input logic [5:0] a);
    logic [15:0] inv;
    logic [6:0]  w;
    logic [11:0] r_p;
    logic [11:0] g_p;
    logic [11:0] b_p;
    logic [15:0] mixed;
    inv   = ~colour;
    w     = {1'b0, a} + 7'd1;
    r_p   = 12'(5'((inv & swac_pkg::RED_FIELD) >> 11)) * 12'(w);
    g_p   = 12'(6'((inv & swac_pkg::GREEN_FIELD) >> 5)) * 12'(w);
    b_p   = 12'(5'(inv & swac_pkg::BLUE_FIELD)) * 12'(w);
    mixed = {r_p[10:6], g_p[11:6], b_p[10:6]};
    return ~mixed;
  endfunction

  logic                a_valid_q, a_valid_d;
  swac_pkg::item_t     a_item_q;
  logic                b_valid_q, b_valid_d;
  swac_pkg::item_t     b_item_q;
  logic                hit_q, hit_d;
  logic signed [10:0]  left_q, left_d;
  logic signed [11:0]  top_q, top_d;
  logic [2:0]          pic_q, pic_d;
  logic                ld_a, ld_b;
  logic signed [13:0]  dx, dy;
  logic                sprite_wr, cover_wr;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic [5:0]          rd_data;
  logic                b_held;

  // Stage handshake: a stage loads when it is empty or its word moves on.
  assign ld_b    = !b_valid_q || ready_i;
  assign ld_a    = !a_valid_q || ld_b;
  assign ready_o = ld_a;
  assign b_held  = b_valid_q && !ready_i;

  // Stage A: position of the pixel relative to this sprite and the store address.
  always_comb begin
    dx = 14'($signed({1'b0, a_item_q.pixel_x})) - 14'(left_q);
    dy = 14'($signed({1'b0, a_item_q.pixel_y})) - 14'(top_q);
    hit_d = (a_item_q.operation == 2'(swac_pkg::OP_PIXEL))
         && (32'(a_item_q.pixel_x) < LINE_WIDTH)
         && (32'(a_item_q.pixel_y) < FRAME_LINES)
         && !dx[13] && (32'(dx[12:0]) < SPRITE_SIZE)
         && !dy[13] && (32'(dy[12:0]) < SPRITE_SIZE)
         && (32'(pic_q) < IMAGE_COUNT);
    rd_addr = ADDR_W'(32'(pic_q) * PLANE + 32'(dy[12:0]) * SPRITE_SIZE + 32'(dx[12:0]));
    wr_addr = ADDR_W'(32'(a_item_q.image_number) * PLANE
                    + 32'(a_item_q.image_row) * SPRITE_SIZE + 32'(a_item_q.image_col));
  end

  // Writes take effect as the word leaves stage A, in stream order.
  always_comb begin
    sprite_wr = ld_b && a_valid_q
             && (a_item_q.operation == 2'(swac_pkg::OP_SPRITE))
             && (32'(a_item_q.sprite_index) == CELL_INDEX);
    cover_wr  = ld_b && a_valid_q
             && (a_item_q.operation == 2'(swac_pkg::OP_COVER))
             && (32'(a_item_q.image_number) < IMAGE_COUNT)
             && (32'(a_item_q.image_row) < SPRITE_SIZE)
             && (32'(a_item_q.image_col) < SPRITE_SIZE);
  end

  // Next values of the valid flags and the sprite entry.
  always_comb begin
    a_valid_d = ld_a ? beat_i.valid : a_valid_q;
    b_valid_d = ld_b ? a_valid_q : b_valid_q;
    left_d    = sprite_wr ? a_item_q.sprite_x_pos : left_q;
    top_d     = sprite_wr ? a_item_q.sprite_y_pos : top_q;
    pic_d     = sprite_wr ? a_item_q.image_number : pic_q;
  end

  // Control state and the sprite entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      left_q    <= '0;
      top_q     <= TOP_RESET;
      pic_q     <= '0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
      left_q    <= left_d;
      top_q     <= top_d;
      pic_q     <= pic_d;
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk_i) begin
    if (ld_a) begin
      a_item_q <= beat_i.item;
    end
    if (ld_b) begin
      b_item_q <= a_item_q;
      hit_q    <= hit_d;
    end
  end

  // This cell's copy of the coverage store.
  swac_ram #(
    .WIDTH (6),
    .DEPTH (DEPTH)
  ) u_cover (
    .clk_i     (clk_i),
    .wr_en_i   (cover_wr),
    .wr_addr_i (wr_addr),
    .wr_data_i (a_item_q.alpha_value),
    .rd_en_i   (ld_b),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Stage B: blend toward white where the sprite covers the pixel.
  always_comb begin
    beat_o.valid = b_valid_q;
    beat_o.item  = b_item_q;
    if (hit_q) begin
      beat_o.item.background_colour = toward_white(b_item_q.background_colour, rd_data);
    end
  end

  `SWAC_ASSERT(a_accept_fills, beat_i.valid && ready_o |=> a_valid_q)
  `SWAC_ASSERT_MSG(a_stall_holds, b_held |=> b_valid_q && $stable(b_item_q), "word moved")
  `SWAC_ASSERT(a_stall_hit, b_held |=> $stable(hit_q))
  `SWAC_ASSERT(a_hit_is_pixel, b_valid_q && hit_q |-> b_item_q.operation == 2'(swac_pkg::OP_PIXEL))

endmodule

FILE: hw/rtl/sprite_white_alpha_compositor.sv
// Top level of the sprite compositor: a chain of sprite cells and the output register.
//
//   Channel  Direction  Words carried
//   in_i     sink       sprite entry writes, coverage writes, background pixels
//   out_o    source     one composited pixel for each background pixel
//
// One word is accepted every cycle unless a stall holds the chain; each word passes
// through two registers per sprite cell and then the output register, where a pixel
// is offered at the output. Each cell holds its own copy of the coverage store, so
// every cell reads it for a different pixel at once. Reset puts every sprite below
// the frame; the coverage store is not cleared. A stall at the output backs up stage
// by stage; empty stages still take words.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sprite_white_alpha_compositor #(
  parameter int unsigned SPRITE_COUNT = swac_pkg::DEF_SPRITE_COUNT,
  parameter int unsigned SPRITE_SIZE  = swac_pkg::DEF_SPRITE_SIZE,
  parameter int unsigned IMAGE_COUNT  = swac_pkg::DEF_IMAGE_COUNT,
  parameter int unsigned LINE_WIDTH   = swac_pkg::DEF_LINE_WIDTH,
  parameter int unsigned FRAME_LINES  = swac_pkg::DEF_FRAME_LINES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swac_in_if.sink    in_i,
  swac_out_if.source out_o
);

  swac_pkg::beat_t chain [SPRITE_COUNT+1];
  logic            rdy   [SPRITE_COUNT+1];
  logic            out_valid_q, out_valid_d;
  logic [15:0]     out_colour_q;
  logic            ld_out;
  logic            tail_pixel;

  // Head of the chain: the input word, fields in item order.
  assign chain[0] = {in_i.valid, in_i.operation, in_i.sprite_index, in_i.sprite_x_pos,
                     in_i.sprite_y_pos, in_i.image_number, in_i.image_row, in_i.image_col,
                     in_i.alpha_value, in_i.pixel_x, in_i.pixel_y, in_i.background_colour};

  assign in_i.ready = rdy[0];

  // One cell per sprite, in table order.
  for (genvar k = 0; k < SPRITE_COUNT; k++) begin : g_cell
    swac_cell #(
      .CELL_INDEX  (k),
      .SPRITE_SIZE (SPRITE_SIZE),
      .IMAGE_COUNT (IMAGE_COUNT),
      .LINE_WIDTH  (LINE_WIDTH),
      .FRAME_LINES (FRAME_LINES)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .beat_i  (chain[k]),
      .ready_o (rdy[k]),
      .beat_o  (chain[k+1]),
      .ready_i (rdy[k+1])
    );
  end

  // Output register: only pixel words produce a result, the rest are dropped.
  assign ld_out            = !out_valid_q || out_o.ready;
  assign rdy[SPRITE_COUNT] = ld_out;
  assign tail_pixel        = chain[SPRITE_COUNT].valid
                          && (chain[SPRITE_COUNT].item.operation == 2'(swac_pkg::OP_PIXEL));

  always_comb begin
    out_valid_d = out_valid_q;
    if (ld_out) begin
      out_valid_d = tail_pixel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      out_colour_q <= chain[SPRITE_COUNT].item.background_colour;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.blended_colour = out_colour_q;

  `SWAC_ASSERT(a_out_from_pixel, $rose(out_valid_q) |-> $past(tail_pixel))
  `SWAC_ASSERT(a_out_holds, out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_colour_q))
  `SWAC_ASSERT(a_pixel_taken, tail_pixel && ld_out |=> out_valid_q)

endmodule
